@@ rtl/lcornh_pkg.sv @@
package lcornh_pkg;

	localparam int N_LANES   = 4;
	localparam int SAMPLE_W  = 7;
	localparam int LVL_W     = 4;
	localparam int CW_W      = 4;
	localparam int SUM_W     = 6;
	localparam int DEN_W     = 9;
	localparam int QUO_W     = 15;
	localparam int HEIGHT_W  = 16;
	localparam int DIV_STEPS = QUO_W;

	localparam int BIT_SAME  = 4;
	localparam int BIT_ABOVE = 5;
	localparam int BIT_SOLID = 6;

	localparam logic [LVL_W-1:0]    LVL_SRC_MIN = 4'd8;
	localparam logic [LVL_W-1:0]    LVL_ZERO    = 4'd0;
	localparam logic [CW_W-1:0]     W_SOURCE    = 4'd11;
	localparam logic [CW_W-1:0]     W_FLOW      = 4'd1;
	localparam logic [CW_W-1:0]     DEPTH_DIV   = 4'd9;
	localparam logic [HEIGHT_W-1:0] Q_ONE       = 16'h8000;

	typedef struct packed {
		logic            above;
		logic [CW_W-1:0] cw;
		logic [CW_W-1:0] ws;
	} lane_t;

	typedef struct packed {
		logic above;
		logic none;
	} flags_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		flags_t           flags;
	} div_t;

endpackage

@@ rtl/lcornh_lane.sv @@
module lcornh_lane
	import lcornh_pkg::*;
(
	input  logic                clk,
	input  logic [SAMPLE_W-1:0] sample,
	output lane_t               lane_s1
);

	logic [LVL_W-1:0] lvl;
	logic             same;
	logic             solid;
	logic             src;
	lane_t            lane_d;

	always_comb begin
		lvl   = sample[LVL_W-1:0];
		same  = sample[BIT_SAME];
		solid = sample[BIT_SOLID];
		src   = (lvl == LVL_ZERO) || (lvl >= LVL_SRC_MIN);
		lane_d.above = sample[BIT_ABOVE];
		if (same) begin
			// source levels all have depth one ninth, so weight times depth is the weight
			lane_d.cw = src ? W_SOURCE : W_FLOW;
			lane_d.ws = src ? W_SOURCE : (lvl + W_FLOW);
		end else if (!solid) begin
			lane_d.cw = W_FLOW;
			lane_d.ws = DEPTH_DIV;
		end else begin
			lane_d.cw = '0;
			lane_d.ws = '0;
		end
	end

	always_ff @(posedge clk) begin
		lane_s1 <= lane_d;
	end

endmodule

@@ rtl/lcornh_merge.sv @@
module lcornh_merge
	import lcornh_pkg::*;
(
	input  logic  clk,
	input  lane_t lanes_s1 [N_LANES],
	output div_t  div_s2
);

	logic [SUM_W-1:0] csum;
	logic [SUM_W-1:0] wsum;
	logic             above;
	logic [DEN_W-1:0] den;
	div_t             div_d;

	always_comb begin
		csum  = '0;
		wsum  = '0;
		above = 1'b0;
		for (int i = 0; i < N_LANES; i++) begin
			csum  = csum + SUM_W'(lanes_s1[i].cw);
			wsum  = wsum + SUM_W'(lanes_s1[i].ws);
			above = above | lanes_s1[i].above;
		end
		den = DEN_W'(csum) * DEN_W'(DEPTH_DIV);
		// every lane keeps its weighted depth at or below nine times its weight
		div_d.rem         = den - DEN_W'(wsum);
		div_d.den         = den;
		div_d.quo         = '0;
		div_d.flags.above = above;
		div_d.flags.none  = (csum == '0);
	end

	always_ff @(posedge clk) begin
		div_s2 <= div_d;
	end

endmodule

@@ rtl/lcornh_div_stage.sv @@
module lcornh_div_stage
	import lcornh_pkg::*;
(
	input  logic clk,
	input  div_t din,
	output div_t dout
);

	logic [DEN_W:0] rem2;
	logic           qbit;
	div_t           d;

	always_comb begin
		rem2    = {din.rem, 1'b0};
		qbit    = (rem2 >= {1'b0, din.den});
		d       = din;
		d.rem   = qbit ? DEN_W'(rem2 - {1'b0, din.den}) : rem2[DEN_W-1:0];
		d.quo   = {din.quo[QUO_W-2:0], qbit};
	end

	always_ff @(posedge clk) begin
		dout <= d;
	end

endmodule

@@ rtl/liquid_corner_height.sv @@
// done: a result strobes on done once its start bit has shifted through the valid chain into the done register
// throughput: one transaction per cycle, busy stays low; the 15-step divider is fully pipelined
// pipeline: lane stage, merge stage, 15 restoring divide stages, output register
// reset: arst_n clears the valid chain and done, in-flight transactions are dropped
// the receiver cannot stall, so no result is ever held back
module liquid_corner_height
	import lcornh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [SAMPLE_W-1:0] sample_0,
	input  logic [SAMPLE_W-1:0] sample_1,
	input  logic [SAMPLE_W-1:0] sample_2,
	input  logic [SAMPLE_W-1:0] sample_3,
	output logic                done,
	output logic [HEIGHT_W-1:0] height,
	output logic                no_samples
);

	localparam int VLD_LEN = DIV_STEPS + 2;

	logic [SAMPLE_W-1:0] samples [N_LANES];
	lane_t               lanes_s1 [N_LANES];
	div_t                chain [DIV_STEPS+1];
	logic [VLD_LEN-1:0]  vld_q;
	logic                done_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                none_q;
	div_t                last;

	assign busy       = 1'b0;
	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;

	for (genvar i = 0; i < N_LANES; i++) begin : g_lane
		lcornh_lane u_lane (
			.clk     (clk),
			.sample  (samples[i]),
			.lane_s1 (lanes_s1[i])
		);
	end

	lcornh_merge u_merge (
		.clk      (clk),
		.lanes_s1 (lanes_s1),
		.div_s2   (chain[0])
	);

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		lcornh_div_stage u_stage (
			.clk  (clk),
			.din  (chain[i]),
			.dout (chain[i+1])
		);
	end

	assign last = chain[DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[VLD_LEN-2:0], start & ~busy};
			done_q <= vld_q[VLD_LEN-1];
		end
	end

	always_ff @(posedge clk) begin
		if (last.flags.above) begin
			height_q <= Q_ONE;
			none_q   <= 1'b0;
		end else if (last.flags.none) begin
			height_q <= '0;
			none_q   <= 1'b1;
		end else begin
			height_q <= HEIGHT_W'(last.quo);
			none_q   <= 1'b0;
		end
	end

	assign done       = done_q;
	assign height     = height_q;
	assign no_samples = none_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##18 done)
		else $error("result strobe missing after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[VLD_LEN-1]))
		else $error("done without a transaction in the pipe");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (height <= Q_ONE))
		else $error("height above one");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && no_samples) |-> (height == '0))
		else $error("height not zero with no samples");

endmodule
